// File: rtl/hmrf_pkg.sv
// Shared types and constants for the HID mouse report framer.
// No dependencies; every other file in rtl/ refers to it by scoped name.
`timescale 1ns / 1ps

package hmrf_pkg;

    typedef enum logic [1:0] {
        OP_MOVE    = 2'd0,
        OP_PRESS   = 2'd1,
        OP_RELEASE = 2'd2,
        OP_TICK    = 2'd3
    } t_opcode;

    // One pending report: the bytes that vary from report to report
    typedef struct packed {
        logic [7:0] buttons;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] scroll;
    } t_report;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    localparam logic [7:0]  INTERVAL_RESET = 8'd20;
    localparam logic [15:0] ELAPSED_MAX    = 16'hFFFF;

    localparam logic [7:0] HDR_ID   = 8'hFD;
    localparam logic [7:0] HDR_PAD  = 8'h00;
    localparam logic [7:0] HDR_KIND = 8'h03;
    localparam logic [7:0] TAIL_PAD = 8'h00;

    // Byte positions within the nine-byte report
    localparam logic [3:0] IDX_ID      = 4'd0;
    localparam logic [3:0] IDX_PAD     = 4'd1;
    localparam logic [3:0] IDX_KIND    = 4'd2;
    localparam logic [3:0] IDX_BUTTONS = 4'd3;
    localparam logic [3:0] IDX_X       = 4'd4;
    localparam logic [3:0] IDX_Y       = 4'd5;
    localparam logic [3:0] IDX_SCROLL  = 4'd6;
    localparam logic [3:0] IDX_TAIL0   = 4'd7;
    localparam logic [3:0] IDX_TAIL1   = 4'd8;

endpackage

// File: rtl/hmrf_front.sv
// Front end: accepts items, keeps button/accumulator/elapsed state and the
// interval register, and pushes a report record when one is due. Uses hmrf_pkg.
`timescale 1ns / 1ps

module hmrf_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [1:0]             i_opcode,
    input  logic signed [7:0]      i_move_x,
    input  logic signed [7:0]      i_move_y,
    input  logic [7:0]             i_scroll,
    input  logic [7:0]             i_button_mask,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [7:0]             i_cfg_send_interval_ms,
    input  hmrf_pkg::t_queue_status i_queue_status,
    output logic                   o_push,
    output hmrf_pkg::t_report      o_push_report
);

    logic [7:0]  r_interval;
    logic [7:0]  r_buttons_now;
    logic [7:0]  r_buttons_sent;
    logic [7:0]  r_accum_x;
    logic [7:0]  r_accum_y;
    logic [15:0] r_elapsed;

    logic [7:0]  n_buttons;
    logic [7:0]  n_accum_x;
    logic [7:0]  n_accum_y;
    logic [7:0]  n_scroll;
    logic        w_is_tick;
    logic        w_due;
    logic        w_accept;
    hmrf_pkg::t_opcode w_op;

    assign o_ready     = !i_queue_status.full;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_valid && o_ready;
    assign w_op        = hmrf_pkg::t_opcode'(i_opcode);

    always_comb begin
        n_buttons = r_buttons_now;
        n_accum_x = r_accum_x;
        n_accum_y = r_accum_y;
        n_scroll  = 8'd0;
        w_is_tick = 1'b0;
        unique case (w_op)
            hmrf_pkg::OP_MOVE: begin
                n_accum_x = r_accum_x + $unsigned(i_move_x);
                n_accum_y = r_accum_y + $unsigned(i_move_y);
                n_scroll  = i_scroll;
            end
            hmrf_pkg::OP_PRESS:   n_buttons = r_buttons_now | i_button_mask;
            hmrf_pkg::OP_RELEASE: n_buttons = r_buttons_now & ~i_button_mask;
            hmrf_pkg::OP_TICK:    w_is_tick = 1'b1;
        endcase
    end

    assign w_due  = (n_buttons != r_buttons_sent) || (r_elapsed > {8'd0, r_interval});
    assign o_push = w_accept && !w_is_tick && w_due;

    always_comb begin
        o_push_report.buttons = n_buttons;
        o_push_report.x       = n_accum_x;
        o_push_report.y       = n_accum_y;
        o_push_report.scroll  = n_scroll;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval     <= hmrf_pkg::INTERVAL_RESET;
            r_buttons_now  <= 8'd0;
            r_buttons_sent <= 8'd0;
            r_accum_x      <= 8'd0;
            r_accum_y      <= 8'd0;
            r_elapsed      <= 16'd0;
        end else begin
            if (i_cfg_valid) begin
                r_interval <= i_cfg_send_interval_ms;
            end
            if (w_accept) begin
                if (w_is_tick) begin
                    // saturate rather than wrap
                    if (r_elapsed != hmrf_pkg::ELAPSED_MAX) begin
                        r_elapsed <= r_elapsed + 16'd1;
                    end
                end else if (w_due) begin
                    r_buttons_now  <= n_buttons;
                    r_buttons_sent <= n_buttons;
                    r_accum_x      <= 8'd0;
                    r_accum_y      <= 8'd0;
                    r_elapsed      <= 16'd0;
                end else begin
                    r_buttons_now <= n_buttons;
                    r_accum_x     <= n_accum_x;
                    r_accum_y     <= n_accum_y;
                end
            end
        end
    end

endmodule

// File: rtl/hmrf_queue.sv
// Two-entry queue of pending report records between front and back end.
// Uses hmrf_pkg for the record and status types.
`timescale 1ns / 1ps

module hmrf_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  hmrf_pkg::t_report       i_push_report,
    input  logic                    i_pop,
    output hmrf_pkg::t_report       o_head,
    output hmrf_pkg::t_queue_status o_status
);

    hmrf_pkg::t_report r_mem [2];
    logic              r_wptr;
    logic              r_rptr;
    logic [1:0]        r_count;

    assign o_head         = r_mem[r_rptr];
    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_report;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/hmrf_back.sv
// Back end: takes report records from the queue and sends them out one byte
// per cycle while i_ready is high, with a last-byte flag. Uses hmrf_pkg for byte positions and constants.
`timescale 1ns / 1ps

module hmrf_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  hmrf_pkg::t_report       i_head,
    input  hmrf_pkg::t_queue_status i_queue_status,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [7:0]              o_report_byte,
    output logic                    o_last_byte
);

    logic              r_active;
    logic [3:0]        r_idx;
    hmrf_pkg::t_report r_rep;
    logic              w_done;

    assign o_valid     = r_active;
    assign o_last_byte = (r_idx == hmrf_pkg::IDX_TAIL1);
    assign w_done      = r_active && i_ready && o_last_byte;
    // load the next record when idle or as the current one finishes
    assign o_pop       = (!r_active || w_done) && !i_queue_status.empty;

    always_comb begin
        unique case (r_idx)
            hmrf_pkg::IDX_ID:      o_report_byte = hmrf_pkg::HDR_ID;
            hmrf_pkg::IDX_PAD:     o_report_byte = hmrf_pkg::HDR_PAD;
            hmrf_pkg::IDX_KIND:    o_report_byte = hmrf_pkg::HDR_KIND;
            hmrf_pkg::IDX_BUTTONS: o_report_byte = r_rep.buttons;
            hmrf_pkg::IDX_X:       o_report_byte = r_rep.x;
            hmrf_pkg::IDX_Y:       o_report_byte = r_rep.y;
            hmrf_pkg::IDX_SCROLL:  o_report_byte = r_rep.scroll;
            hmrf_pkg::IDX_TAIL0:   o_report_byte = hmrf_pkg::TAIL_PAD;
            hmrf_pkg::IDX_TAIL1:   o_report_byte = hmrf_pkg::TAIL_PAD;
            default:               o_report_byte = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rep <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= hmrf_pkg::IDX_ID;
        end else if (o_pop) begin
            r_active <= 1'b1;
            r_idx    <= hmrf_pkg::IDX_ID;
        end else if (w_done) begin
            r_active <= 1'b0;
            r_idx    <= hmrf_pkg::IDX_ID;
        end else if (r_active && i_ready) begin
            r_idx <= r_idx + 4'd1;
        end
    end

endmodule

// File: rtl/hid_mouse_report_framer.sv
// Top level of the HID mouse report framer: front end, report queue, back end.
// Depends on hmrf_pkg, hmrf_front, hmrf_queue and hmrf_back.
`timescale 1ns / 1ps

// Takes move, press, release and tick requests and emits nine-byte raw HID
// mouse reports (FD 00 03 buttons X Y scroll 00 00), one byte per cycle while
// i_ready is high, with o_last_byte on the ninth. A request is taken while the
// report queue has room; any request, ticks and non-reporting requests included,
// waits while the queue is full. Reports are sent by the one-byte-per-cycle
// serializer, and reporting requests are taken ahead of it until the queue
// fills. Two report records queue ahead of the
// serializer; input ready drops only while that queue is full. The interval
// register is written through the cfg channel, which is always ready, and must
// only be written while the block is idle.
module hid_mouse_report_framer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_opcode,
    input  logic signed [7:0] i_move_x,
    input  logic signed [7:0] i_move_y,
    input  logic [7:0]        i_scroll,
    input  logic [7:0]        i_button_mask,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [7:0]        i_cfg_send_interval_ms,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_report_byte,
    output logic              o_last_byte
);

    hmrf_pkg::t_queue_status w_queue_status;
    hmrf_pkg::t_report       w_push_report;
    hmrf_pkg::t_report       w_head;
    logic                    w_push;
    logic                    w_pop;

    hmrf_front u_front (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (i_valid),
        .o_ready                (o_ready),
        .i_opcode               (i_opcode),
        .i_move_x               (i_move_x),
        .i_move_y               (i_move_y),
        .i_scroll               (i_scroll),
        .i_button_mask          (i_button_mask),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_send_interval_ms (i_cfg_send_interval_ms),
        .i_queue_status         (w_queue_status),
        .o_push                 (w_push),
        .o_push_report          (w_push_report)
    );

    hmrf_queue u_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (w_push),
        .i_push_report (w_push_report),
        .i_pop         (w_pop),
        .o_head        (w_head),
        .o_status      (w_queue_status)
    );

    hmrf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_head),
        .i_queue_status (w_queue_status),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_report_byte  (o_report_byte),
        .o_last_byte    (o_last_byte)
    );

    // A full queue can never also read empty
    a_queue_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_queue_status.full |-> !w_queue_status.empty)
        else $error("report queue full and empty at once");

    // Never push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_queue_status.full |-> !w_push)
        else $error("push into full report queue");

    // After a report's last byte goes out, any next byte opens a new report
    a_report_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last_byte) |=>
            (!o_valid || o_report_byte == hmrf_pkg::HDR_ID))
        else $error("report did not restart with header byte");

    // A queued record is picked up while the serializer is idle
    a_pick_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid && !w_queue_status.empty) |-> w_pop)
        else $error("serializer idle with a queued report");

endmodule

// File: bench/tb_top.sv
// Self-checking bench for hid_mouse_report_framer: move, press, release and tick requests
// go in, and each report byte that comes out is checked against a behavioral predictor.
// Depends on rtl/hmrf_pkg.sv and rtl/hid_mouse_report_framer.sv.
`timescale 1ns / 1ps

module tb_top;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } t_report_beat;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [1:0]        i_opcode;
    logic signed [7:0] i_move_x;
    logic signed [7:0] i_move_y;
    logic [7:0]        i_scroll;
    logic [7:0]        i_button_mask;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [7:0]        i_cfg_send_interval_ms;
    logic              o_valid;
    logic              i_ready;
    logic [7:0]        o_report_byte;
    logic              o_last_byte;

    // Predictor state
    logic [7:0]  interval_ms = hmrf_pkg::INTERVAL_RESET;
    logic [7:0]  buttons_held = 8'h00;
    logic [7:0]  buttons_reported = 8'h00;
    logic [7:0]  pending_x = 8'h00;
    logic [7:0]  pending_y = 8'h00;
    logic [15:0] ms_since_report = 16'h0000;

    t_report_beat expected_report_bytes[$];
    t_report_beat head_beat;

    bit idling = 1'b1;
    int error_count = 0;
    int requests_sent = 0;
    int reports_predicted = 0;
    int bytes_checked = 0;

    hid_mouse_report_framer uut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (i_valid),
        .o_ready                (o_ready),
        .i_opcode               (i_opcode),
        .i_move_x               (i_move_x),
        .i_move_y               (i_move_y),
        .i_scroll               (i_scroll),
        .i_button_mask          (i_button_mask),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_send_interval_ms (i_cfg_send_interval_ms),
        .o_valid                (o_valid),
        .i_ready                (i_ready),
        .o_report_byte          (o_report_byte),
        .o_last_byte            (o_last_byte)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #8_000_000;
        $display("timeout with %0d report bytes outstanding", expected_report_bytes.size());
        $display("tb_top: errors");
        $finish;
    end

    // Update the framer state for one request and queue any report it causes
    task automatic predict_report(input hmrf_pkg::t_opcode op, input logic [7:0] dx_in,
                                  input logic [7:0] dy_in, input logic [7:0] wheel_in,
                                  input logic [7:0] mask);
        logic [7:0] dx;
        logic [7:0] dy;
        logic [7:0] wheel;
        logic [7:0] frame [9];
        t_report_beat beat;
        dx = 8'h00;
        dy = 8'h00;
        wheel = 8'h00;
        if (op == hmrf_pkg::OP_TICK) begin
            if (ms_since_report != hmrf_pkg::ELAPSED_MAX)
                ms_since_report = ms_since_report + 16'd1;
        end else begin
            case (op)
                hmrf_pkg::OP_MOVE: begin
                    dx = dx_in;
                    dy = dy_in;
                    wheel = wheel_in;
                end
                hmrf_pkg::OP_PRESS: buttons_held = buttons_held | mask;
                default:            buttons_held = buttons_held & ~mask;
            endcase
            pending_x = pending_x + dx;
            pending_y = pending_y + dy;
            if (buttons_held != buttons_reported || ms_since_report > {8'h00, interval_ms}) begin
                frame = '{hmrf_pkg::HDR_ID, hmrf_pkg::HDR_PAD, hmrf_pkg::HDR_KIND,
                          buttons_held, pending_x, pending_y,
                          wheel, hmrf_pkg::TAIL_PAD, hmrf_pkg::TAIL_PAD};
                for (int k = 0; k < 9; k++) begin
                    beat.value = frame[k];
                    beat.last = (k == 8);
                    expected_report_bytes.push_back(beat);
                end
                reports_predicted++;
                ms_since_report = 16'h0000;
                pending_x = 8'h00;
                pending_y = 8'h00;
                buttons_reported = buttons_held;
            end
        end
    endtask

    // Valid stays high across back-to-back requests; drop it only for a gap
    task automatic send_request(input hmrf_pkg::t_opcode op, input logic [7:0] dx,
                                input logic [7:0] dy, input logic [7:0] wheel,
                                input logic [7:0] mask);
        if (idling && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_opcode      <= op;
        i_move_x      <= dx;
        i_move_y      <= dy;
        i_scroll      <= wheel;
        i_button_mask <= mask;
        do @(posedge i_clk); while (!o_ready);
        predict_report(op, dx, dy, wheel, mask);
        requests_sent++;
    endtask

    task automatic send_tick();
        send_request(hmrf_pkg::OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom));
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_tick();
    endtask

    // Write the interval only once the framer has drained
    task automatic set_send_interval(input logic [7:0] ms);
        i_valid <= 1'b0;
        while (expected_report_bytes.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        i_cfg_valid            <= 1'b1;
        i_cfg_send_interval_ms <= ms;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        interval_ms = ms;
    endtask

    task automatic flag_error(input string what);
        error_count++;
        if (error_count <= 10)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // Output side: random stall bursts while idling is on
    initial begin
        i_ready = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (idling && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            bytes_checked++;
            if (expected_report_bytes.size() == 0) begin
                flag_error($sformatf("unexpected byte %02h last %b", o_report_byte, o_last_byte));
            end else begin
                head_beat = expected_report_bytes.pop_front();
                if (o_report_byte !== head_beat.value)
                    flag_error($sformatf("report byte expected %02h got %02h",
                                         head_beat.value, o_report_byte));
                if (o_last_byte !== head_beat.last)
                    flag_error($sformatf("last flag expected %b got %b",
                                         head_beat.last, o_last_byte));
            end
        end
    end

    // Extremes of every field, wrap of the accumulators, no-change presses
    task automatic test_field_extremes();
        send_request(hmrf_pkg::OP_MOVE, 8'h7F, 8'h80, 8'hFF, 8'hFF);
        send_request(hmrf_pkg::OP_MOVE, 8'h80, 8'h7F, 8'h00, 8'h00);
        send_request(hmrf_pkg::OP_PRESS, 8'h7F, 8'h80, 8'hFF, 8'hFF);
        send_request(hmrf_pkg::OP_RELEASE, 8'h00, 8'h00, 8'h55, 8'h0F);
        send_request(hmrf_pkg::OP_PRESS, 8'h11, 8'h22, 8'h33, 8'h00);
        send_request(hmrf_pkg::OP_RELEASE, 8'h80, 8'h80, 8'hAA, 8'hFF);
        send_request(hmrf_pkg::OP_RELEASE, 8'h01, 8'h01, 8'h01, 8'h07);
        send_request(hmrf_pkg::OP_MOVE, 8'h7F, 8'h7F, 8'h00, 8'h00);
        send_request(hmrf_pkg::OP_MOVE, 8'h7F, 8'h80, 8'h00, 8'h00);
        send_request(hmrf_pkg::OP_MOVE, 8'h80, 8'h80, 8'h00, 8'h00);
        send_ticks(20);
        send_request(hmrf_pkg::OP_MOVE, 8'h01, 8'hFF, 8'hA5, 8'h00);
        send_tick();
        send_request(hmrf_pkg::OP_MOVE, 8'h01, 8'h80, 8'h5A, 8'hFF);
        send_request(hmrf_pkg::OP_PRESS, 8'h00, 8'h00, 8'h00, 8'h01);
        send_request(hmrf_pkg::OP_PRESS, 8'h00, 8'h00, 8'h00, 8'h02);
        send_request(hmrf_pkg::OP_PRESS, 8'h00, 8'h00, 8'h00, 8'h04);
        send_request(hmrf_pkg::OP_RELEASE, 8'h00, 8'h00, 8'h00, 8'h02);
        send_request(hmrf_pkg::OP_RELEASE, 8'h00, 8'h00, 8'h00, 8'h05);
    endtask

    task automatic test_interval_zero();
        set_send_interval(8'd0);
        send_request(hmrf_pkg::OP_MOVE, 8'h05, 8'hFB, 8'h01, 8'h00);
        send_tick();
        send_request(hmrf_pkg::OP_MOVE, 8'h03, 8'h04, 8'h02, 8'h00);
        send_request(hmrf_pkg::OP_MOVE, 8'h03, 8'h04, 8'h02, 8'h00);
        send_request(hmrf_pkg::OP_PRESS, 8'h00, 8'h00, 8'h00, 8'h04);
        send_ticks(3);
        send_request(hmrf_pkg::OP_RELEASE, 8'h00, 8'h00, 8'h00, 8'h00);
    endtask

    // Report the buttons first so the count starts from zero
    task automatic test_interval_max();
        set_send_interval(8'd255);
        send_request(hmrf_pkg::OP_PRESS, 8'h00, 8'h00, 8'h00, 8'h80);
        send_ticks(255);
        send_request(hmrf_pkg::OP_MOVE, 8'h10, 8'h20, 8'h30, 8'h00);
        send_tick();
        send_request(hmrf_pkg::OP_MOVE, 8'h01, 8'h02, 8'h03, 8'h00);
    endtask

    task automatic test_random_traffic(input int count);
        int done;
        int pick;
        int burst;
        logic [7:0] mask;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 28) begin
                send_request(hmrf_pkg::OP_MOVE, 8'($urandom), 8'($urandom), 8'($urandom),
                             8'($urandom));
                done += 1;
            end else if (pick < 40) begin
                send_request(hmrf_pkg::OP_PRESS, 8'($urandom), 8'($urandom), 8'($urandom),
                             8'($urandom));
                done += 1;
            end else if (pick < 52) begin
                send_request(hmrf_pkg::OP_RELEASE, 8'($urandom), 8'($urandom),
                             8'($urandom), 8'($urandom));
                done += 1;
            end else if (pick < 62) begin
                send_tick();
                done += 1;
            end else if (pick < 80) begin
                // let the rate limit run out, then move
                if (interval_ms < 64)
                    burst = interval_ms + $urandom_range(0, 2);
                else
                    burst = $urandom_range(1, 8);
                send_ticks(burst);
                send_request(hmrf_pkg::OP_MOVE, 8'($urandom), 8'($urandom), 8'($urandom),
                             8'($urandom));
                done += burst + 1;
            end else begin
                // click: press, maybe drag, release the same buttons
                mask = 8'($urandom);
                send_request(hmrf_pkg::OP_PRESS, 8'($urandom), 8'($urandom), 8'($urandom),
                             mask);
                if ($urandom_range(0, 1)) begin
                    send_request(hmrf_pkg::OP_MOVE, 8'($urandom), 8'($urandom),
                                 8'($urandom), 8'($urandom));
                    done += 1;
                end
                send_request(hmrf_pkg::OP_RELEASE, 8'($urandom), 8'($urandom),
                             8'($urandom), mask);
                done += 2;
            end
        end
    endtask

    task automatic test_back_to_back(input int count);
        set_send_interval(8'd2);
        idling = 1'b0;
        test_random_traffic(count);
    endtask

    initial begin
        i_rst_n                = 1'b0;
        i_valid                = 1'b0;
        i_opcode               = hmrf_pkg::OP_MOVE;
        i_move_x               = 8'h00;
        i_move_y               = 8'h00;
        i_scroll               = 8'h00;
        i_button_mask          = 8'h00;
        i_cfg_valid            = 1'b0;
        i_cfg_send_interval_ms = 8'h00;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_field_extremes();
        test_interval_zero();
        test_interval_max();
        set_send_interval(hmrf_pkg::INTERVAL_RESET);
        test_random_traffic(30);
        set_send_interval(8'd0);
        test_random_traffic(20);
        set_send_interval(8'($urandom_range(1, 10)));
        test_random_traffic(20);
        set_send_interval(8'd255);
        test_random_traffic(10);
        set_send_interval(8'($urandom_range(0, 255)));
        test_random_traffic(10);
        test_back_to_back(30);

        i_valid <= 1'b0;
        while (expected_report_bytes.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        $display("covered %0d requests over intervals 0, 20, 255 and random values;",
                 requests_sent);
        $display("%0d reports predicted, %0d bytes checked, %0d mismatches",
                 reports_predicted, bytes_checked, error_count);
        if (error_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
